@@ sv/wls_pkg.sv @@
package wls_pkg;

	// Defaults for the top-level parameters
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int NUM_CHANNELS_DEF = 16;

	// Field widths of the item and result ports
	localparam int MODE_W    = 1;
	localparam int CHANNEL_W = 4;
	localparam int SAMPLE_W  = 16;
	localparam int FILL_W    = 7;
	localparam int VALUE_W   = 17;
	localparam int MEAN_W    = 25;
	localparam int FRAC_W    = 8;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_ADD   = 1'b0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 1'b1;

	// Readings of an empty window: -1 and -1.0 in Q8
	localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -17'sd1;
	localparam logic signed [MEAN_W-1:0]  EMPTY_MEAN  = -25'sd256;

endpackage

@@ sv/windowed_latency_statistics_unit.sv @@
// Windowed latency statistics. Each channel keeps a ring window of its latest
// WINDOW_DEPTH samples in one shared sample memory. An item with mode add
// appends sample_ms to its channel (dropping the oldest sample once the
// window is full); mode clear empties the channel. Every item gives one
// result: the fill level, the newest sample, the minimum, the maximum and
// the mean as floor(sum * 256 / count). An empty window, a cleared channel
// and a channel number at or above NUM_CHANNELS read -1 for the samples and
// -256 (-1.0) for the mean; an out-of-range channel is otherwise ignored.
// The block takes one item at a time and holds in_stall high until the
// result transfer completes. An add item writes its sample, then the scan
// reads one stored sample per cycle through the single memory port and
// feeds the shared min, max and sum unit, then the divider retires one
// quotient bit per cycle. Clear items skip the scan and the divide, and
// out-of-range items go straight to the result. No clearing pass is
// needed after reset: each channel carries a valid bit, and samples are
// only read once written.
module windowed_latency_statistics_unit #(
	parameter int WINDOW_DEPTH = wls_pkg::WINDOW_DEPTH_DEF,
	parameter int NUM_CHANNELS = wls_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [wls_pkg::MODE_W-1:0]                mode,
	input  logic [wls_pkg::CHANNEL_W-1:0]             channel,
	input  logic [wls_pkg::SAMPLE_W-1:0]              sample_ms,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [wls_pkg::FILL_W-1:0]                fill_level,
	output logic signed [wls_pkg::VALUE_W-1:0]        newest,
	output logic signed [wls_pkg::VALUE_W-1:0]        smallest,
	output logic signed [wls_pkg::VALUE_W-1:0]        largest,
	output logic signed [wls_pkg::MEAN_W-1:0]         mean_q8
);
	import wls_pkg::*;

	// Derived widths
	localparam int PW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;   // slot index
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);                        // fill count
	localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;   // channel index
	localparam int MEMD = NUM_CHANNELS * WINDOW_DEPTH;
	localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;                   // sample address
	localparam int SW   = SAMPLE_W + CW;                                   // window sum
	localparam int DW   = SW + FRAC_W;                                     // dividend
	localparam int SCW  = $clog2(DW + 1);                                  // divide steps

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_META = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [PW-1:0] pos;
		logic [CW-1:0] cnt;
	} meta_t;

	state_t state_q;

	// Per-channel ring state: write position and fill count, plus valid bits
	meta_t             meta_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] chan_vld_q;
	meta_t             meta_rd_q;
	logic              meta_hit_q;

	// Sample store, one port
	logic [SAMPLE_W-1:0] smp_mem [MEMD];
	logic [SAMPLE_W-1:0] smp_rd_q;
	logic                smp_we;
	logic [AW-1:0]       smp_addr;

	// Item under work
	logic [MODE_W-1:0]   mode_q;
	logic [CHW-1:0]      ch_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic                rdv_q;

	// Shared accumulate unit and divider
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SW-1:0]       sum_q;
	logic [DW-1:0]       quo_q;
	logic [CW-1:0]       rem_q;
	logic [SCW-1:0]      step_q;

	// Result register
	logic [FILL_W-1:0]          fill_q;
	logic signed [VALUE_W-1:0]  newest_q;
	logic signed [VALUE_W-1:0]  lo_out_q;
	logic signed [VALUE_W-1:0]  hi_out_q;
	logic signed [MEAN_W-1:0]   mean_q;

	logic          in_xfer;
	logic          in_range;
	logic [CHW-1:0] ch_in;
	logic [PW-1:0] cur_pos;
	logic [CW-1:0] cur_cnt;
	logic [PW-1:0] nxt_pos;
	logic [CW-1:0] nxt_cnt;
	logic [AW-1:0] base_addr;
	logic          rd_issue;
	logic [CW:0]   div_sh;
	logic          div_ge;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign in_range  = (32'(channel) < NUM_CHANNELS);
	assign ch_in     = CHW'(channel);

	// Channel state as seen after its valid bit: never written or cleared reads as empty
	assign cur_pos = meta_hit_q ? meta_rd_q.pos : '0;
	assign cur_cnt = meta_hit_q ? meta_rd_q.cnt : '0;
	assign nxt_pos = (32'(cur_pos) == WINDOW_DEPTH - 1) ? '0 : cur_pos + 1'b1;
	assign nxt_cnt = (32'(cur_cnt) == WINDOW_DEPTH) ? cur_cnt : cur_cnt + 1'b1;

	assign base_addr = AW'(ch_q) * AW'(WINDOW_DEPTH);

	// The window holds slots 0 .. count-1 whether or not it has wrapped,
	// so walk them in slot order; min, max and sum do not care about age.
	assign rd_issue = (state_q == ST_SCAN) && (idx_q < cnt_q);

	always_comb begin
		smp_we   = (state_q == ST_META) && (mode_q == MODE_ADD);
		smp_addr = base_addr + AW'(idx_q[PW-1:0]);
		if (smp_we) begin
			smp_addr = base_addr + AW'(cur_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[smp_addr] <= sample_q;
		end
		smp_rd_q <= smp_mem[smp_addr];
	end

	// Channel state memory: read on the item transfer, written back in META
	always_ff @(posedge clk) begin
		if (state_q == ST_META && mode_q == MODE_ADD) begin
			meta_mem[ch_q] <= '{pos: nxt_pos, cnt: nxt_cnt};
		end
		meta_rd_q <= meta_mem[ch_in];
	end

	// Restoring divide step: shift in one dividend bit, subtract if it fits
	assign div_sh = {rem_q, quo_q[DW-1]};
	assign div_ge = (div_sh >= {1'b0, cnt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chan_vld_q <= '0;
			meta_hit_q <= 1'b0;
			rdv_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						meta_hit_q <= in_range && chan_vld_q[ch_in];
						if (in_range) begin
							state_q <= ST_META;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_META: begin
					rdv_q <= 1'b0;
					if (mode_q == MODE_CLEAR) begin
						// Drop the valid bit: the channel reads as empty from now on
						chan_vld_q[ch_q] <= 1'b0;
						state_q          <= ST_OUT;
					end else begin
						chan_vld_q[ch_q] <= 1'b1;
						state_q          <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rdv_q <= rd_issue;
					// Advance once the last read has been folded in
					if (!rd_issue && !rdv_q) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == SCW'(DW)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q   <= mode;
				ch_q     <= ch_in;
				sample_q <= sample_ms;
				fill_q   <= '0;
				newest_q <= EMPTY_VALUE;
				lo_out_q <= EMPTY_VALUE;
				hi_out_q <= EMPTY_VALUE;
				mean_q   <= EMPTY_MEAN;
			end
			ST_META: begin
				cnt_q <= nxt_cnt;
				idx_q <= '0;
				lo_q  <= '1;
				hi_q  <= '0;
				sum_q <= '0;
			end
			ST_SCAN: begin
				if (rd_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rdv_q) begin
					if (smp_rd_q < lo_q) begin
						lo_q <= smp_rd_q;
					end
					if (smp_rd_q > hi_q) begin
						hi_q <= smp_rd_q;
					end
					sum_q <= sum_q + SW'(smp_rd_q);
				end
				rem_q  <= '0;
				step_q <= '0;
				if (rdv_q) begin
					quo_q <= {sum_q + SW'(smp_rd_q), {FRAC_W{1'b0}}};
				end else begin
					quo_q <= {sum_q, {FRAC_W{1'b0}}};
				end
			end
			ST_DIV: begin
				if (step_q == SCW'(DW)) begin
					fill_q   <= FILL_W'(cnt_q);
					newest_q <= VALUE_W'({1'b0, sample_q});
					lo_out_q <= VALUE_W'({1'b0, lo_q});
					hi_out_q <= VALUE_W'({1'b0, hi_q});
					mean_q   <= MEAN_W'(quo_q);
				end else begin
					step_q <= step_q + 1'b1;
					quo_q  <= {quo_q[DW-2:0], div_ge};
					rem_q  <= div_ge ? CW'(div_sh - {1'b0, cnt_q}) : CW'(div_sh);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = (state_q == ST_OUT);
	assign fill_level = fill_q;
	assign newest     = newest_q;
	assign smallest   = lo_out_q;
	assign largest    = hi_out_q;
	assign mean_q8    = mean_q;

endmodule

@@ sv/wls_checker.sv @@
module wls_props (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [wls_pkg::FILL_W-1:0]         fill_level,
	input logic signed [wls_pkg::VALUE_W-1:0] newest,
	input logic signed [wls_pkg::VALUE_W-1:0] smallest,
	input logic signed [wls_pkg::VALUE_W-1:0] largest,
	input logic signed [wls_pkg::MEAN_W-1:0]  mean_q8
);
	import wls_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fill_level) && $stable(newest)
			&& $stable(smallest) && $stable(largest) && $stable(mean_q8))
		else $error("stalled result changed");

	// One item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// No new item while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	// An empty reading is empty in every field
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && newest == EMPTY_VALUE |-> fill_level == '0
			&& smallest == EMPTY_VALUE && largest == EMPTY_VALUE && mean_q8 == EMPTY_MEAN)
		else $error("inconsistent empty reading");

	// A filled window orders its extremes
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && newest != EMPTY_VALUE |-> smallest <= largest
			&& smallest <= newest && newest <= largest)
		else $error("min, newest and max out of order");

endmodule

bind windowed_latency_statistics_unit wls_props u_wls_props (.*);

@@ sim/wls_checker.sv @@
module wls_checker #(
	parameter int WINDOW_DEPTH = wls_pkg::WINDOW_DEPTH_DEF,
	parameter int NUM_CHANNELS = wls_pkg::NUM_CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [wls_pkg::MODE_W-1:0]         mode,
	input  logic [wls_pkg::CHANNEL_W-1:0]      channel,
	input  logic [wls_pkg::SAMPLE_W-1:0]       sample_ms,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [wls_pkg::FILL_W-1:0]         fill_level,
	input  logic signed [wls_pkg::VALUE_W-1:0] newest,
	input  logic signed [wls_pkg::VALUE_W-1:0] smallest,
	input  logic signed [wls_pkg::VALUE_W-1:0] largest,
	input  logic signed [wls_pkg::MEAN_W-1:0]  mean_q8,
	output int                                 errors,
	output int                                 pending,
	output int                                 results,
	output int                                 full_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import wls_pkg::*;

	typedef struct packed {
		logic [FILL_W-1:0]         fill;
		logic signed [VALUE_W-1:0] newest;
		logic signed [VALUE_W-1:0] smallest;
		logic signed [VALUE_W-1:0] largest;
		logic signed [MEAN_W-1:0]  mean;
	} reading_t;

	logic [SAMPLE_W-1:0] window_mem [NUM_CHANNELS][WINDOW_DEPTH];
	int unsigned         head_pos [NUM_CHANNELS];
	int unsigned         held [NUM_CHANNELS];
	reading_t            pending_readings [$];
	int                  n_errors;
	int                  n_results;
	int                  n_full;

	// Apply one item to the shadow windows and return the reading it yields.
	function automatic reading_t advance_window(input logic [MODE_W-1:0] m,
			input int unsigned ch, input logic [SAMPLE_W-1:0] smp);
		reading_t          r;
		int unsigned       first;
		int unsigned       cnt;
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		longint unsigned   total;
		r.fill     = '0;
		r.newest   = EMPTY_VALUE;
		r.smallest = EMPTY_VALUE;
		r.largest  = EMPTY_VALUE;
		r.mean     = EMPTY_MEAN;
		if (ch >= NUM_CHANNELS)
			return r;
		if (m == MODE_CLEAR) begin
			held[ch]     = 0;
			head_pos[ch] = 0;
		end else begin
			window_mem[ch][head_pos[ch]] = smp;
			head_pos[ch] = (head_pos[ch] + 1) % WINDOW_DEPTH;
			if (held[ch] < WINDOW_DEPTH)
				held[ch]++;
		end
		cnt = held[ch];
		if (cnt == 0)
			return r;
		// Oldest sample sits at slot 0 until the ring wraps, then at the head.
		first = (cnt < WINDOW_DEPTH) ? 0 : head_pos[ch];
		lo    = '1;
		hi    = '0;
		total = 0;
		for (int i = 0; i < cnt; i++) begin
			v = window_mem[ch][(first + i) % WINDOW_DEPTH];
			if (v < lo)
				lo = v;
			if (v > hi)
				hi = v;
			total += v;
		end
		r.fill     = FILL_W'(cnt);
		r.newest   = {1'b0, window_mem[ch][(head_pos[ch] + WINDOW_DEPTH - 1) % WINDOW_DEPTH]};
		r.smallest = {1'b0, lo};
		r.largest  = {1'b0, hi};
		r.mean     = MEAN_W'((total << FRAC_W) / cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			pending_readings.delete();
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				head_pos[c] = 0;
				held[c]     = 0;
			end
			n_errors  = 0;
			n_results = 0;
			n_full    = 0;
		end else begin
			// Retire the result before queuing a new item on the same edge.
			if (out_valid && !out_stall) begin
				got = {fill_level, newest, smallest, largest, mean_q8};
				n_results++;
				if (got.fill == WINDOW_DEPTH)
					n_full++;
				if (pending_readings.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%t: unexpected result fill %0d newest %0d min %0d max %0d mean %0d",
							$realtime, got.fill, got.newest, got.smallest, got.largest,
							got.mean);
				end else begin
					want = pending_readings.pop_front();
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"%t: result %0d mismatch: expected fill %0d newest %0d",
								" min %0d max %0d mean %0d, got fill %0d newest %0d",
								" min %0d max %0d mean %0d"}, $realtime, n_results,
								want.fill, want.newest, want.smallest, want.largest,
								want.mean, got.fill, got.newest, got.smallest,
								got.largest, got.mean);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_readings.push_back(advance_window(mode, channel, sample_ms));
		end
		errors       <= n_errors;
		pending      <= pending_readings.size();
		results      <= n_results;
		full_results <= n_full;
	end

endmodule

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wls_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	// Give the tail a margin beyond the slowest item.
	localparam int TAIL_CYCLES  = 150;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [MODE_W-1:0]           mode;
	logic [CHANNEL_W-1:0]        channel;
	logic [SAMPLE_W-1:0]         sample_ms;
	logic                        out_valid;
	logic                        out_stall;
	logic [FILL_W-1:0]           fill_level;
	logic signed [VALUE_W-1:0]   newest;
	logic signed [VALUE_W-1:0]   smallest;
	logic signed [VALUE_W-1:0]   largest;
	logic signed [MEAN_W-1:0]    mean_q8;
	int                          errors;
	int                          pending;
	int                          results;
	int                          full_results;

	// Sender bookkeeping for the closing summary.
	int                          n_items;
	int                          n_clears;
	int                          n_directed;
	bit                          calm_tx;

	windowed_latency_statistics_unit dut (.*);

	wls_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs; the slowest correct run needs about
	// a tenth of this.
	initial begin
		#3_000_000;
		$display("FAIL windowed_latency_statistics_unit");
		$finish;
	end

	// Drive one item: idle for a drawn gap (none in calm stretches), then
	// hold the payload until the block takes it. Valid stays high across
	// back-to-back items so it is never dropped and raised in one step.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [CHANNEL_W-1:0] c,
			input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		channel   <= c;
		sample_ms <= s;
		do
			@(posedge clk);
		while (in_stall);
		n_items++;
		if (m == MODE_CLEAR)
			n_clears++;
	endtask

	// Drop valid and wait until every queued reading has come back.
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	// Keep most traffic on two hot channels so their windows fill and wrap.
	function automatic logic [CHANNEL_W-1:0] pick_channel();
		if ($urandom_range(0, 1))
			return CHANNEL_W'($urandom_range(0, 1));
		return CHANNEL_W'($urandom_range(0, 15));
	endfunction

	// Mix full-range values with the extremes and a cluster of tiny values,
	// so min, max and the rounding of the mean all see edge values.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 2)
			return '0;
		if (sel < 4)
			return '1;
		if (sel < 7)
			return SAMPLE_W'($urandom_range(0, 15));
		return SAMPLE_W'($urandom);
	endfunction

	// Receiver: stall for a drawn number of cycles before each result, then
	// release and wait for the transfer. Every fifth stretch runs with no
	// backpressure at all.
	initial begin
		int hold;
		int n_rx;
		out_stall = 1'b0;
		n_rx      = 0;
		@(posedge arst_n);
		forever begin
			hold = (((n_rx / 70) % 5) == 2) ? 0 : $urandom_range(0, 13);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
			n_rx++;
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_ADD;
		channel   = '0;
		sample_ms = '0;
		n_items   = 0;
		n_clears  = 0;
		calm_tx   = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, a clear of a filled and of an empty channel,
		// the largest possible mean, and means that need rounding down.
		send_item(MODE_ADD, 4'd0, 16'd0);
		send_item(MODE_ADD, 4'd0, 16'hFFFF);
		send_item(MODE_ADD, 4'd0, 16'd1);
		send_item(MODE_CLEAR, 4'd0, SAMPLE_W'($urandom));
		send_item(MODE_CLEAR, 4'd0, SAMPLE_W'($urandom));
		send_item(MODE_ADD, 4'd0, 16'd42);
		send_item(MODE_ADD, 4'd15, 16'hFFFF);
		send_item(MODE_CLEAR, 4'd7, 16'hFFFF);
		send_item(MODE_ADD, 4'd5, 16'h5555);
		send_item(MODE_ADD, 4'd5, 16'hAAAA);
		send_item(MODE_CLEAR, 4'd15, 16'h0000);
		send_item(MODE_ADD, 4'd15, 16'd7);
		send_item(MODE_ADD, 4'd15, 16'd4);
		send_item(MODE_ADD, 4'd3, 16'd1);
		send_item(MODE_ADD, 4'd3, 16'd1);
		send_item(MODE_ADD, 4'd3, 16'd2);
		send_item(MODE_ADD, 4'd3, 16'hFFFF);
		send_item(MODE_ADD, 4'd3, 16'd0);
		send_item(MODE_CLEAR, 4'd3, SAMPLE_W'($urandom));
		send_item(MODE_ADD, 4'd3, 16'h8000);
		n_directed = n_items;

		// Let the pipe run empty once before the random part.
		hold_until_drained();

		// Random: mostly adds with rare clears; one stretch in four with no
		// sender gaps, and one more full drain midway.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			calm_tx = ((k / 90) % 4) == 2;
			if (k == RANDOM_ITEMS / 2)
				hold_until_drained();
			if ($urandom_range(0, 99) == 0)
				send_item(MODE_CLEAR, pick_channel(), SAMPLE_W'($urandom));
			else
				send_item(MODE_ADD, pick_channel(), pick_sample());
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d directed, %0d clears) over %0d channels.",
			n_items, n_directed, n_clears, NUM_CHANNELS_DEF);
		$display("Checked %0d readings, %0d of them from a full wrapping window.",
			results, full_results);
		if (errors == 0 && pending == 0)
			$display("PASS windowed_latency_statistics_unit");
		else
			$display("FAIL windowed_latency_statistics_unit");
		$finish;
	end

endmodule
